// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the tag extractor modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property check, sampled on the rising clock, off while in reset.
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error(msg);

// Same-cycle implication check.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    `ASSERT_AT(lbl, clk_s, rst_s, (ante) |-> (cons), msg)

// Next-cycle implication check.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    `ASSERT_AT(lbl, clk_s, rst_s, (ante) |=> (cons), msg)

`else

`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ale_pkg.sv -----
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants of the Accept-Language tag extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

    // Tag store capacity; a tag holds at most TAG_CAPACITY - 1 characters.
    localparam int TAG_CAPACITY = 32;
    localparam int MAX_CHARS    = TAG_CAPACITY - 1;
    localparam int CNT_W        = $clog2(TAG_CAPACITY);

    // Character ring between the front and back ends.
    localparam int RING_DEPTH = 2 * TAG_CAPACITY;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int PTR_W      = RING_AW + 1;

    // Queue of committed tag lengths.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Character codes.
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    typedef logic [CNT_W-1:0] tag_len_t;
    typedef logic [PTR_W-1:0] ring_ptr_t;

    // Input transaction: one header byte.
    typedef struct packed {
        logic [7:0] header_byte;
        logic       header_last;
    } ale_in_t;

    // Output transaction: one tag character.
    typedef struct packed {
        logic [7:0] tag_char;
        logic       tag_last;
    } ale_out_t;

    // Ring write port from the front end.
    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic [7:0]         data;
    } ale_wr_t;

    // Length queue status toward both ends.
    typedef struct packed {
        logic     nonempty;
        logic     full;
        tag_len_t head;
    } ale_q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ale_len_queue.sv -----
// ----------------------------------------------------------------------------
// ale_len_queue
// Short FIFO of committed tag lengths between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ale_len_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ale_pkg::tag_len_t push_len,
    input  wire logic              pop,
    output ale_pkg::ale_q_stat_t   stat
);
    import ale_pkg::*;

    tag_len_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0]     wr_ptr_reg;
    logic [QUEUE_AW:0]     rd_ptr_reg;
    logic [QUEUE_AW:0]     wr_ptr_next;
    logic [QUEUE_AW:0]     rd_ptr_next;

    // Pointer arithmetic; the extra bit tells full from empty.
    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    assign stat.nonempty = (wr_ptr_reg != rd_ptr_reg);
    assign stat.full     = (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0])
                           && (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]);
    assign stat.head     = entry_reg[rd_ptr_reg[QUEUE_AW-1:0]];

    // Pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg[QUEUE_AW-1:0]] <= push_len;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ale_front.sv -----
// ----------------------------------------------------------------------------
// ale_front
// Header parser: classifies bytes, writes tag characters into the ring and
// commits the length of every valid tag to the length queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ale_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ale_pkg::ale_in_t  in_data,
    input  wire ale_pkg::ale_q_stat_t q_stat,
    input  wire ale_pkg::ring_ptr_t rd_ptr,
    output ale_pkg::ale_wr_t       wr,
    output logic                   push,
    output ale_pkg::tag_len_t      push_len
);
    import ale_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIPWS,
        PH_COLLECT,
        PH_SKIPCOMMA
    } phase_t;

    phase_t     phase_reg, phase_next;
    tag_len_t   cnt_reg, cnt_next;
    logic       inv_reg, inv_next;
    ring_ptr_t  base_reg, base_next;
    logic       underscore_reg;

    logic       accept;
    logic [7:0] c;
    logic [7:0] cl;
    logic       is_ws;
    logic       char_ok;
    ring_ptr_t  used;

    tag_len_t   t_cnt, tk_cnt, cnt_a;
    logic       t_inv, tk_inv, inv_a;
    logic       tk_we, tk_full, fl;
    phase_t     phase_a;

    // Ring occupancy; the front holds off while the ring or queue is full.
    assign used     = base_reg + ring_ptr_t'(cnt_reg) - rd_ptr;
    assign in_stall = (used == ring_ptr_t'(RING_DEPTH)) || q_stat.full;
    assign accept   = in_valid && !in_stall;

    // Byte classification and case folding.
    assign c     = in_data.header_byte;
    assign is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    always_comb
    begin
        if ((c == CH_UNDERSCORE) && underscore_reg)
        begin
            cl = CH_HYPHEN;
        end
        else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
        begin
            cl = c + CASE_OFFSET;
        end
        else
        begin
            cl = c;
        end
    end
    assign char_ok = (cl == CH_HYPHEN) || (cl == CH_STAR)
                     || ((cl >= CH_LOWER_A) && (cl <= CH_LOWER_Z));

    // Taking one tag character; a new tag starts from an empty state.
    always_comb
    begin
        t_cnt  = (phase_reg == PH_SKIPWS) ? '0 : cnt_reg;
        t_inv  = (phase_reg == PH_SKIPWS) ? 1'b0 : inv_reg;
        tk_cnt = t_cnt;
        tk_inv = t_inv;
        tk_we  = 1'b0;
        if (!t_inv)
        begin
            if (!char_ok)
            begin
                tk_inv = 1'b1;
            end
            else if (t_cnt < tag_len_t'(MAX_CHARS))
            begin
                tk_we  = 1'b1;
                tk_cnt = t_cnt + 1'b1;
            end
        end
        tk_full = !t_inv && char_ok && (tk_cnt >= tag_len_t'(MAX_CHARS));
    end

    // Phase decoding and tag commit.
    always_comb
    begin
        phase_a = phase_reg;
        cnt_a   = cnt_reg;
        inv_a   = inv_reg;
        fl      = 1'b0;
        wr.en   = 1'b0;
        unique case (phase_reg)
            PH_SKIPWS:
            begin
                if (is_ws || (c == CH_COMMA))
                begin
                    phase_a = PH_SKIPWS;
                end
                else if (c == CH_SEMICOLON)
                begin
                    phase_a = PH_SKIPCOMMA;
                end
                else
                begin
                    cnt_a   = tk_cnt;
                    inv_a   = tk_inv;
                    wr.en   = accept && tk_we;
                    fl      = tk_full;
                    phase_a = tk_full ? PH_SKIPCOMMA : PH_COLLECT;
                end
            end
            PH_COLLECT:
            begin
                if (c == CH_COMMA)
                begin
                    fl      = 1'b1;
                    phase_a = PH_SKIPWS;
                end
                else if ((c == CH_SEMICOLON) || is_ws)
                begin
                    fl      = 1'b1;
                    phase_a = PH_SKIPCOMMA;
                end
                else
                begin
                    cnt_a   = tk_cnt;
                    inv_a   = tk_inv;
                    wr.en   = accept && tk_we;
                    fl      = tk_full;
                    phase_a = tk_full ? PH_SKIPCOMMA : PH_COLLECT;
                end
            end
            default:
            begin
                phase_a = (c == CH_COMMA) ? PH_SKIPWS : PH_SKIPCOMMA;
            end
        endcase

        // End of header flushes a tag still being collected.
        if (in_data.header_last && (phase_a == PH_COLLECT))
        begin
            fl = 1'b1;
        end

        push     = accept && fl && (cnt_a != '0) && !inv_a;
        push_len = cnt_a;
        wr.addr  = RING_AW'(base_reg + ring_ptr_t'(t_cnt));
        wr.data  = cl;

        if (!accept)
        begin
            phase_next = phase_reg;
            cnt_next   = cnt_reg;
            inv_next   = inv_reg;
            base_next  = base_reg;
        end
        else
        begin
            phase_next = in_data.header_last ? PH_SKIPWS : phase_a;
            cnt_next   = (fl || in_data.header_last) ? '0 : cnt_a;
            inv_next   = (fl || in_data.header_last) ? 1'b0 : inv_a;
            base_next  = push ? base_reg + ring_ptr_t'(cnt_a) : base_reg;
        end
    end

    // Parser state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SKIPWS;
            cnt_reg        <= '0;
            inv_reg        <= 1'b0;
            base_reg       <= '0;
            underscore_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            inv_reg   <= inv_next;
            base_reg  <= base_next;
            if (cfg_we)
            begin
                underscore_reg <= cfg_data;
            end
        end
    end

    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= tag_len_t'(MAX_CHARS),
        "tag count exceeds capacity")
    `ASSERT_IMPL(a_push_nonempty, clk, rst_n, push, push_len != '0,
        "empty tag committed")
    `ASSERT_NEXT(a_last_resets, clk, rst_n, accept && in_data.header_last,
        (phase_reg == PH_SKIPWS) && (cnt_reg == '0) && !inv_reg,
        "parser state not cleared after end of header")
    `ASSERT_IMPL(a_ring_bound, clk, rst_n, 1'b1, used <= ring_ptr_t'(RING_DEPTH),
        "ring overrun")

endmodule

`default_nettype wire

// ----- hw/rtl/ale_back.sv -----
// ----------------------------------------------------------------------------
// ale_back
// Emitter: holds the character ring and plays committed tags out one
// character per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ale_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ale_pkg::ale_wr_t     wr,
    input  wire ale_pkg::ale_q_stat_t q_stat,
    output logic                      pop,
    output ale_pkg::ring_ptr_t        rd_ptr,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output ale_pkg::ale_out_t         out_data
);
    import ale_pkg::*;

    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] rdata_reg;
    logic       last_reg;
    logic       valid_reg;
    ring_ptr_t  rd_ptr_reg;
    tag_len_t   cnt_reg;
    logic       load;
    logic       is_last;

    // Load the output register when it is free or being taken.
    assign load    = q_stat.nonempty && (!valid_reg || !out_stall);
    assign is_last = ({1'b0, cnt_reg} + 1'b1) == {1'b0, q_stat.head};
    assign pop     = load && is_last;

    assign rd_ptr            = rd_ptr_reg;
    assign out_valid         = valid_reg;
    assign out_data.tag_char = rdata_reg;
    assign out_data.tag_last = last_reg;

    // Character ring: written by the parser, read here.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ring_mem[wr.addr] <= wr.data;
        end
        if (load)
        begin
            rdata_reg <= ring_mem[rd_ptr_reg[RING_AW-1:0]];
            last_reg  <= is_last;
        end
    end

    // Read pointer, position in the tag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg  <= 1'b1;
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                cnt_reg    <= is_last ? '0 : cnt_reg + 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_IMPL(a_head_nonzero, clk, rst_n, q_stat.nonempty, q_stat.head != '0,
        "zero-length tag at queue head")
    `ASSERT_IMPL(a_cnt_in_tag, clk, rst_n, q_stat.nonempty, cnt_reg < q_stat.head,
        "character index past tag length")
    `ASSERT_NEXT(a_tag_done, clk, rst_n, pop, (cnt_reg == '0) && valid_reg && last_reg,
        "tag end not presented after pop")

endmodule

`default_nettype wire

// ----- hw/rtl/accept_language_tag_extractor.sv -----
// ----------------------------------------------------------------------------
// accept_language_tag_extractor
// Splits an Accept-Language header into lowercase language tags.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one header byte per transaction, with
//   header_last on the final byte. The output channel carries one tag
//   character per transaction, with tag_last on the final character of a tag.
//   Both channels transfer when valid is high and stall is low.
//   cfg_we/cfg_data set the underscore-to-hyphen option; write it while idle.
// Timing:
//   A byte is taken every cycle. Characters go into a 64-entry ring and
//   each finished tag's length into a 4-entry queue; the input stalls only
//   while the ring is full or four tags wait to be sent.
//   The byte ending a tag registers its length in the queue; the output
//   register then loads the first character, and the rest follow one per
//   cycle while out_stall is low, limited by the single ring read port.
// Reset and stall:
//   rst_n clears the parser, the ring pointers and the queue; underscore
//   rewriting is off. A stalled output holds its character, and the parser
//   keeps running until the ring or queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module accept_language_tag_extractor (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ale_pkg::ale_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output ale_pkg::ale_out_t     out_data
);
    import ale_pkg::*;

    ale_wr_t     wr;
    ale_q_stat_t q_stat;
    ring_ptr_t   rd_ptr;
    logic        push;
    tag_len_t    push_len;
    logic        pop;

    // Parser front end.
    ale_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .rd_ptr   (rd_ptr),
        .wr       (wr),
        .push     (push),
        .push_len (push_len)
    );

    // Committed tag lengths.
    ale_len_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_len (push_len),
        .pop      (pop),
        .stat     (q_stat)
    );

    // Emitter back end.
    ale_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .q_stat    (q_stat),
        .pop       (pop),
        .rd_ptr    (rd_ptr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Accept-Language tag extractor. Header values
// are sent one byte per transaction, and a scoreboard predicts the emitted
// tag characters and checks each character and its last flag in order.
// Both channels idle at random. The sink once holds off long enough to fill
// the block. The underscore option is changed between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import ale_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD = 250;
    localparam int IDLE_LIMIT = 2000;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] SPACE_SET [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    typedef logic [7:0] byte_q_t[$];

    // Parser position within the header.
    typedef enum logic [1:0] {
        SCAN_SPACE,
        SCAN_TAG,
        SCAN_TO_COMMA
    } scan_state_t;

    // Predicts the tag characters and checks them in arrival order.
    class tag_scoreboard;
        bit          underscore_on = 1'b0;
        scan_state_t state = SCAN_SPACE;
        logic [7:0]  tag_buf [TAG_CAPACITY];
        int unsigned tag_len = 0;
        bit          tag_bad = 1'b0;
        ale_out_t    expected_q[$];
        int unsigned errors = 0;

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
                   c == CH_FF || c == CH_CR;
        endfunction

        // Queue the pending tag if it is valid and non-empty, then clear it.
        function void emit_tag();
            ale_out_t item;
            if (tag_len > 0 && !tag_bad)
            begin
                for (int i = 0; i < tag_len; i++)
                begin
                    item.tag_char = tag_buf[i];
                    item.tag_last = (i + 1 == tag_len);
                    expected_q.push_back(item);
                end
            end
            tag_len = 0;
            tag_bad = 1'b0;
        endfunction

        // Add one character to the tag; returns 1 once the tag is full.
        function bit add_char(logic [7:0] raw);
            logic [7:0] c;
            c = raw;
            if (tag_bad)
                return 1'b0;
            if (c == CH_UNDERSCORE && underscore_on)
                c = CH_HYPHEN;
            else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                c = c + CASE_OFFSET;
            if (c != CH_HYPHEN && c != CH_STAR && (c < CH_LOWER_A || c > CH_LOWER_Z))
            begin
                tag_bad = 1'b1;
                return 1'b0;
            end
            if (tag_len < MAX_CHARS)
            begin
                tag_buf[tag_len] = c;
                tag_len++;
            end
            return tag_len >= MAX_CHARS;
        endfunction

        // Advance the parser by one accepted header byte.
        function void note_byte(ale_in_t item);
            logic [7:0] c;
            c = item.header_byte;
            case (state)
                SCAN_SPACE:
                begin
                    if (is_space(c) || c == CH_COMMA)
                    begin
                        // An empty list item is consumed here.
                    end
                    else if (c == CH_SEMICOLON)
                    begin
                        state = SCAN_TO_COMMA;
                    end
                    else
                    begin
                        tag_len = 0;
                        tag_bad = 1'b0;
                        state = SCAN_TAG;
                        if (add_char(c))
                        begin
                            emit_tag();
                            state = SCAN_TO_COMMA;
                        end
                    end
                end
                SCAN_TAG:
                begin
                    if (c == CH_COMMA)
                    begin
                        emit_tag();
                        state = SCAN_SPACE;
                    end
                    else if (c == CH_SEMICOLON || is_space(c))
                    begin
                        emit_tag();
                        state = SCAN_TO_COMMA;
                    end
                    else if (add_char(c))
                    begin
                        emit_tag();
                        state = SCAN_TO_COMMA;
                    end
                end
                default:
                begin
                    state = (c == CH_COMMA) ? SCAN_SPACE : SCAN_TO_COMMA;
                end
            endcase
            // The end of the header flushes a tag in progress.
            if (item.header_last)
            begin
                if (state == SCAN_TAG)
                    emit_tag();
                state = SCAN_SPACE;
                tag_len = 0;
                tag_bad = 1'b0;
            end
        endfunction

        // Compare one emitted character with the oldest prediction.
        function void check_char(ale_out_t got);
            ale_out_t want;
            if (expected_q.size() == 0)
            begin
                $error("tag_char: unexpected character %h (tag_last %b)",
                       got.tag_char, got.tag_last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.tag_char !== want.tag_char)
            begin
                $error("tag_char: expected %h, actual %h", want.tag_char, got.tag_char);
                errors++;
            end
            if (got.tag_last !== want.tag_last)
            begin
                $error("tag_last: expected %b, actual %b", want.tag_last, got.tag_last);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic     cfg_data;
    logic     in_valid;
    logic     in_stall;
    ale_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    ale_out_t out_data;

    tag_scoreboard sb;
    bit            send_burst = 1'b0;
    bit            hold_request = 1'b0;
    int unsigned   send_calm = 0;
    int unsigned   sink_calm = 0;
    int unsigned   idle_cycles = 0;

    accept_language_tag_extractor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Idle cycles before a transaction, with occasional runs of no idling.
    function automatic int unsigned draw_gap(inout int unsigned calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm_left = $urandom_range(5, 20);
        return $urandom_range(0, 15);
    endfunction

    function automatic void add_text(inout byte_q_t hdr, input string s);
        for (int i = 0; i < s.len(); i++)
            hdr.push_back(s[i]);
    endfunction

    // A mostly well-formed header with random content and some broken items.
    function automatic byte_q_t random_header(int unsigned long_len);
        byte_q_t     hdr;
        int unsigned items;
        int unsigned len;
        items = $urandom_range(1, 4);
        for (int i = 0; i < items; i++)
        begin
            repeat ($urandom_range(0, 2)) hdr.push_back(SPACE_SET[$urandom_range(0, 5)]);
            if ($urandom_range(0, 7) == 0)
                hdr.push_back($urandom_range(0, 1) ? CH_SEMICOLON : CH_COMMA);
            len = (i == 0 && long_len != 0) ? long_len : $urandom_range(1, 8);
            repeat (len)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                        hdr.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
                    11, 12, 13, 14:
                        hdr.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
                    15: hdr.push_back(CH_HYPHEN);
                    16: hdr.push_back(CH_STAR);
                    17: hdr.push_back(CH_UNDERSCORE);
                    18: hdr.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: hdr.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            // Quality value suffix.
            if ($urandom_range(0, 3) == 0)
            begin
                hdr.push_back(CH_SEMICOLON);
                hdr.push_back("q");
                hdr.push_back(CH_EQUALS);
                hdr.push_back(CH_ZERO);
                hdr.push_back(CH_DOT);
                hdr.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if (i != items - 1)
            begin
                hdr.push_back(CH_COMMA);
                if ($urandom_range(0, 1))
                    hdr.push_back(CH_SPACE);
            end
        end
        if ($urandom_range(0, 5) == 0)
            hdr.push_back($urandom_range(0, 1) ? CH_COMMA : SPACE_SET[$urandom_range(0, 5)]);
        return hdr;
    endfunction

    // Offer one header byte and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input bit last);
        ale_in_t     item;
        int unsigned gap;
        item.header_byte = b;
        item.header_last = last;
        gap = send_burst ? 0 : draw_gap(send_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_header(input byte_q_t hdr);
        foreach (hdr[i])
            send_byte(hdr[i], i == hdr.size() - 1);
    endtask

    // Random headers until the byte budget is spent.
    task automatic send_random(input int unsigned budget, input bit with_long_tag);
        byte_q_t     hdr;
        int unsigned sent;
        sent = 0;
        while (sent < budget)
        begin
            if (with_long_tag && sent == 0)
            begin
                hdr = random_header($urandom_range(MAX_CHARS - 1, MAX_CHARS + 3));
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                hdr = {};
                repeat ($urandom_range(1, 6)) hdr.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                hdr = random_header(0);
            end
            send_header(hdr);
            sent += hdr.size();
        end
    endtask

    // Stop sending and wait until every predicted character has come out.
    // The first edge lets the monitor note the final byte before the check.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_underscore(input bit value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.underscore_on = value;
    endtask

    // Transaction monitors on both channels.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_byte(in_data);
        if (rst_n && out_valid && !out_stall)
            sb.check_char(out_data);
    end

    // Count cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        int unsigned pause;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            pause = draw_gap(sink_calm);
            if (pause != 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Main sequence.
    initial
    begin : stimulus
        byte_q_t hdr;
        sb = new;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed headers with underscore rewriting off. The first covers
        // every whitespace byte, case folding, star and hyphen, an empty
        // item, a semicolon before any tag and an underscore that spoils
        // the last tag.
        write_underscore(1'b0);
        hdr = {};
        foreach (SPACE_SET[i])
            hdr.push_back(SPACE_SET[i]);
        add_text(hdr, "Za-*,,;x,y_");
        send_header(hdr);
        // Control and high bytes spoil tags; the end of the header flushes.
        hdr = {8'h00, CH_COMMA, "Q", 8'hFF, 8'h80, CH_COMMA, "a"};
        send_header(hdr);
        drain();

        // Underscore rewriting on.
        write_underscore(1'b1);
        hdr = {};
        add_text(hdr, "en_US");
        send_header(hdr);
        send_random(20, 1'b1);
        drain();

        // Back-to-back input while the sink holds off. Many short tags fill
        // the length queue, so the block stalls its input.
        write_underscore(1'b0);
        send_burst = 1'b1;
        hold_request = 1'b1;
        hdr = {};
        add_text(hdr, "a,b,c,d,e,f,g,h,i,j");
        send_header(hdr);
        send_random(5, 1'b0);
        send_burst = 1'b0;
        drain();

        write_underscore(1'b1);
        send_random(10, 1'b0);
        drain();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- accept_language_tag_extractor.f -----
+incdir+hw/rtl
hw/rtl/ale_pkg.sv
hw/rtl/ale_len_queue.sv
hw/rtl/ale_front.sv
hw/rtl/ale_back.sv
hw/rtl/accept_language_tag_extractor.sv
bench/tb_top.sv
